// ===== rtl/core/perfect_square_root_2adic_defines.svh =====
// Assertion macros for the perfect-square root block.
`ifndef PERFECT_SQUARE_ROOT_2ADIC_DEFINES_SVH
`define PERFECT_SQUARE_ROOT_2ADIC_DEFINES_SVH

// Plain property, checked at every clock edge outside reset.
`define PSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/psr_pkg.sv =====
// Shared types, constants and multiply helpers for the perfect-square root pipeline.
package psr_pkg;

    // Refinement steps; five reach full 64-bit precision.
    localparam int NewtonSteps = 5;
    // Register stages inside one refinement step.
    localparam int StepStages = 4;

    localparam logic [63:0] Three = 64'd3;

    // Payload that travels between the pipeline sections.
    typedef struct packed {
        logic        rej;   // already known not to be a square
        logic [4:0]  sh;    // half of the removed trailing-zero count
        logic [63:0] inv;   // inverse square root estimate
        logic [63:0] r;     // square root estimate
    } t_lane;

    // Partial products of a 64x64 multiply kept modulo 2^64.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_pp;

    function automatic t_pp pp_mul(input logic [63:0] a, input logic [63:0] b);
        t_pp p;
        p.ll = 64'(a[31:0]) * 64'(b[31:0]);
        p.lh = a[31:0] * b[63:32];
        p.hl = a[63:32] * b[31:0];
        return p;
    endfunction

    function automatic logic [63:0] pp_sum(input t_pp p);
        return p.ll + {p.lh + p.hl, 32'd0};
    endfunction

endpackage

// ===== rtl/core/psr_front.sv =====
// Front section: trailing-zero strip, residue check, seed and first product.
module psr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [63:0]     i_value,
    output logic            o_vld,
    output psr_pkg::t_lane  o_lane
);
    import psr_pkg::*;

    logic [3:0]  r_v;
    logic [63:0] r_val1;
    logic [5:0]  r_tz1;
    t_lane       r_l2;
    t_lane       r_l3;
    t_pp         r_pp3;
    t_lane       r_l4;

    logic [63:0] low_bit;
    logic [5:0]  tz;
    logic [63:0] odd;

    // Isolate lowest set bit, then encode. Zero encodes as 0 and still
    // comes out as a square with root 0.
    always_comb begin
        low_bit = i_value & (~i_value + 64'd1);
        tz      = '0;
        for (int b = 0; b < 64; b++) begin
            if (low_bit[b]) begin
                tz = tz | 6'(b);
            end
        end
    end

    assign odd = r_val1 >> {r_tz1[5:1], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val1 <= i_value;
            r_tz1  <= tz;

            r_l2.rej <= odd[1] | odd[2];
            r_l2.sh  <= r_tz1[5:1];
            r_l2.inv <= (Three - odd) >> 1;
            r_l2.r   <= odd;

            r_l3  <= r_l2;
            r_pp3 <= pp_mul(r_l2.r, r_l2.inv);

            r_l4.rej <= r_l3.rej;
            r_l4.sh  <= r_l3.sh;
            r_l4.inv <= r_l3.inv;
            r_l4.r   <= pp_sum(r_pp3);
        end
    end

    assign o_vld  = r_v[3];
    assign o_lane = r_l4;

endmodule

// ===== rtl/core/psr_newton_step.sv =====
// One 2-adic Newton step for the inverse square root, four register stages.
module psr_newton_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  psr_pkg::t_lane  i_lane,
    output logic            o_vld,
    output psr_pkg::t_lane  o_lane
);
    import psr_pkg::*;

    logic [StepStages-1:0] r_v;
    t_lane       r_l1;
    t_pp         r_pp1;
    t_lane       r_l2;
    logic [63:0] r_corr;
    t_lane       r_l3;
    t_pp         r_ppr;
    t_pp         r_ppi;
    t_lane       r_l4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[StepStages-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // inv * r
            r_l1  <= i_lane;
            r_pp1 <= pp_mul(i_lane.inv, i_lane.r);
            // corr = (3 - inv*r) / 2
            r_l2   <= r_l1;
            r_corr <= (Three - pp_sum(r_pp1)) >> 1;
            // both estimates scaled by corr
            r_l3  <= r_l2;
            r_ppr <= pp_mul(r_l2.r, r_corr);
            r_ppi <= pp_mul(r_l2.inv, r_corr);
            r_l4.rej <= r_l3.rej;
            r_l4.sh  <= r_l3.sh;
            r_l4.r   <= pp_sum(r_ppr);
            r_l4.inv <= pp_sum(r_ppi);
        end
    end

    assign o_vld  = r_v[StepStages-1];
    assign o_lane = r_l4;

endmodule

// ===== rtl/core/psr_back.sv =====
// Back section: sign normalization, range check, shift back, output register.
module psr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  psr_pkg::t_lane  i_lane,
    output logic            o_vld,
    output logic            o_is_square,
    output logic [31:0]     o_root
);
    import psr_pkg::*;

    logic        r_v1;
    logic        r_v2;
    logic [62:0] r_rn;
    logic        r_rej;
    logic [4:0]  r_sh;
    logic        r_sq;
    logic [31:0] r_root;

    logic [63:0] neg_r;
    logic        ok;

    assign neg_r = 64'd0 - i_lane.r;
    assign ok    = !r_rej && (r_rn[62:32] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // pick the representative with bit 62 clear, drop bit 63
            r_rn  <= i_lane.r[62] ? neg_r[62:0] : i_lane.r[62:0];
            r_rej <= i_lane.rej;
            r_sh  <= i_lane.sh;
            r_sq   <= ok;
            r_root <= ok ? (r_rn[31:0] << r_sh) : 32'd0;
        end
    end

    assign o_vld       = r_v2;
    assign o_is_square = r_sq;
    assign o_root      = r_root;

endmodule

// ===== rtl/core/perfect_square_root_2adic.sv =====
// Top level of the 64-bit perfect-square test with exact square root.
`include "perfect_square_root_2adic_defines.svh"

// Streaming perfect-square tester. Each request on the slave side carries one
// unsigned 64-bit value; for each one the master side returns exactly one
// result, in order: tuser is 1 when the value is a perfect square, and tdata
// then holds its exact root (0 otherwise). Zero is reported as a square with
// root 0. The datapath is a fixed-depth pipeline that takes one value every
// clock cycle while the output is not held off: 4 stages strip the even
// part of the trailing zeros, check the residue mod 8 and form the first
// product, each of the 5 Newton steps takes 4 stages (three 64-bit products
// modulo 2^64, each split over 32x32 partial products and a summing stage),
// and 2 stages normalize, range-check and shift the root back; the last of
// these is the output register. When the output is held off, the whole pipe
// freezes in place, so nothing is dropped or repeated, and o_s_tready is low
// only while a finished result is waiting and i_m_tready is low.
module perfect_square_root_2adic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    // result side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] root
    output logic        o_m_tuser    // [0] is_square
);
    import psr_pkg::*;

    // global advance: the pipe moves unless a result sits unclaimed
    logic                 en;
    logic [NewtonSteps:0] vld;
    t_lane                lane [0:NewtonSteps];

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    psr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_value (i_s_tdata),
        .o_vld   (vld[0]),
        .o_lane  (lane[0])
    );

    // chain of Newton refinement steps
    for (genvar k = 0; k < NewtonSteps; k++) begin : g_step
        psr_newton_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[k]),
            .i_lane  (lane[k]),
            .o_vld   (vld[k+1]),
            .o_lane  (lane[k+1])
        );
    end

    psr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (vld[NewtonSteps]),
        .i_lane      (lane[NewtonSteps]),
        .o_vld       (o_m_tvalid),
        .o_is_square (o_m_tuser),
        .o_root      (o_m_tdata)
    );

    // A rejected value must carry a zero root.
    `PSR_ASSERT(a_reject_zero_root, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 32'd0), "non-square result with nonzero root")
    // Input side is open exactly when the output register can move.
    `PSR_ASSERT(a_stall_link, o_s_tready == (!o_m_tvalid || i_m_tready), "ready not tied to output stall")
    // Pipe comes out of reset empty.
    `PSR_ASSERT_NEXT(a_reset_empty, 1'b1, !$past(!i_rst_n) || !o_m_tvalid, "result valid right after reset")

endmodule
